### src/clle_pkg.sv
// Shared codes for the circular linked list engine: command and status encodings.
// No dependencies; the files that use it refer to it by scoped names.
package clle_pkg;

  typedef logic [2:0] cmd_t;
  typedef logic [1:0] status_t;

  localparam cmd_t CMD_APPEND = 3'd0;
  localparam cmd_t CMD_INSERT_FRONT = 3'd1;
  localparam cmd_t CMD_FIRST = 3'd2;
  localparam cmd_t CMD_NEXT = 3'd3;
  localparam cmd_t CMD_REMOVE = 3'd4;

  localparam status_t ST_OK = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL = 2'd2;
  localparam status_t ST_NOCUR = 2'd3;

endpackage

### src/clle_if.sv
// Valid/ready channel interfaces for the command and result words.
// Depends on clle_pkg for the command and status types.
interface clle_in_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                  valid;
  logic                  ready;
  clle_pkg::cmd_t        command;
  logic [DATA_WIDTH-1:0] data_in;

  modport source(output valid, output command, output data_in, input ready);
  modport sink(input valid, input command, input data_in, output ready);
endinterface

interface clle_out_if #(
  parameter int DATA_WIDTH  = 32,
  parameter int COUNT_WIDTH = 5
) ();
  logic                   valid;
  logic                   ready;
  logic [DATA_WIDTH-1:0]  data_out;
  clle_pkg::status_t      status;
  logic [COUNT_WIDTH-1:0] count;

  modport source(output valid, output data_out, output status, output count, input ready);
  modport sink(input valid, input data_out, input status, input count, output ready);
endinterface

### src/circular_linked_list_engine_top.sv
// Commands pass through the input register and the core; results wait in the result register.
// Throughput: one command per cycle without back pressure; clle_list_core keeps the list state.
// The input register refills in the same cycle it drains, so back pressure alone stalls intake.
// Reset (rst_n low, synchronous): empty list, no cursor, all slots free, both registers empty.
// Depends on clle_pkg, clle_if, clle_free_slot and clle_list_core.
module circular_linked_list_engine_top #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  clle_in_if.sink    in_ch,
  clle_out_if.source out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);

  // input register
  logic                  in_valid_r;
  clle_pkg::cmd_t        in_cmd_r;
  logic [DATA_WIDTH-1:0] in_data_r;

  // result register
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_data_r;
  clle_pkg::status_t     out_status_r;
  logic [CW-1:0]         out_count_r;

  logic                  fire;
  logic [DATA_WIDTH-1:0] res_data;
  clle_pkg::status_t     res_status;
  logic [CW-1:0]         res_count;

  // advance a held command when the result slot is free or being emptied
  assign fire        = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || fire;

  clle_list_core #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .cmd        (in_cmd_r),
    .data_in    (in_data_r),
    .res_data   (res_data),
    .res_status (res_status),
    .res_count  (res_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // hold the input word until the core takes it
      if (in_ch.ready) in_valid_r <= in_ch.valid;
      // load a fresh result, or drop the old one once taken
      if (fire) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_cmd_r  <= in_ch.command;
      in_data_r <= in_ch.data_in;
    end
    if (fire) begin
      out_data_r   <= res_data;
      out_status_r <= res_status;
      out_count_r  <= res_count;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = out_data_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.count    = out_count_r;

endmodule

### src/clle_free_slot.sv
// Lowest-free-slot finder over the used-slot bitmap.
// No package dependencies.
module clle_free_slot #(
  parameter int CAPACITY = 16
) (
  input  logic [CAPACITY-1:0]         used,
  output logic [$clog2(CAPACITY)-1:0] slot_idx,
  output logic                        slot_found
);

  localparam int IW = $clog2(CAPACITY);

  always_comb begin
    slot_idx   = '0;
    slot_found = 1'b0;
    // scan from the top so the lowest free slot wins
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used[i]) begin
        slot_idx   = IW'(i);
        slot_found = 1'b1;
      end
    end
  end

endmodule

### src/clle_list_core.sv
// List state and single-pass command logic: node pool, bitmap, tail and cursor.
// Depends on clle_pkg and clle_free_slot.
module clle_list_core #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fire,
  input  clle_pkg::cmd_t                   cmd,
  input  logic [DATA_WIDTH-1:0]            data_in,
  output logic [DATA_WIDTH-1:0]            res_data,
  output clle_pkg::status_t                res_status,
  output logic [$clog2(CAPACITY+1)-1:0]    res_count
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [DATA_WIDTH-1:0] node_data_r [CAPACITY];
  logic [IW-1:0]         node_link_r [CAPACITY];
  logic [CAPACITY-1:0]   slot_used_r, slot_used_nxt;
  logic [IW-1:0]         tail_r, tail_nxt;
  logic                  nonempty_r, nonempty_nxt;
  logic [IW-1:0]         cur_r, cur_nxt;
  logic [IW-1:0]         prv_r, prv_nxt;
  logic                  cur_valid_r, cur_valid_nxt;
  logic [CW-1:0]         count_r, count_nxt;

  logic [IW-1:0] free_idx;
  logic          free_found;

  logic          data_we;
  logic [IW-1:0] data_widx;
  logic          link_we_a, link_we_b;
  logic [IW-1:0] link_idx_a, link_val_a, link_idx_b, link_val_b;

  logic [IW-1:0] head_idx, cur_link, prv_link, rd_idx;

  clle_free_slot #(.CAPACITY(CAPACITY)) u_free (
    .used       (slot_used_r),
    .slot_idx   (free_idx),
    .slot_found (free_found)
  );

  assign head_idx = node_link_r[tail_r];
  assign cur_link = node_link_r[cur_r];
  assign prv_link = node_link_r[prv_r];
  assign rd_idx   = (cmd == clle_pkg::CMD_FIRST) ? head_idx :
                    (cmd == clle_pkg::CMD_NEXT)  ? cur_link : cur_r;

  always_comb begin
    slot_used_nxt = slot_used_r;
    tail_nxt      = tail_r;
    nonempty_nxt  = nonempty_r;
    cur_nxt       = cur_r;
    prv_nxt       = prv_r;
    cur_valid_nxt = cur_valid_r;
    count_nxt     = count_r;
    data_we       = 1'b0;
    data_widx     = free_idx;
    link_we_a     = 1'b0;
    link_idx_a    = free_idx;
    link_val_a    = free_idx;
    link_we_b     = 1'b0;
    link_idx_b    = tail_r;
    link_val_b    = free_idx;
    res_data      = '0;
    res_status    = clle_pkg::ST_OK;

    case (cmd)
      clle_pkg::CMD_APPEND, clle_pkg::CMD_INSERT_FRONT: begin
        if (count_r >= CAP_CNT || !free_found) begin
          res_status = clle_pkg::ST_FULL;
        end else begin
          data_we                 = 1'b1;
          slot_used_nxt[free_idx] = 1'b1;
          link_we_a               = 1'b1;
          count_nxt               = count_r + 1'b1;
          if (!nonempty_r) begin
            // lone node links to itself and becomes the tail
            tail_nxt     = free_idx;
            nonempty_nxt = 1'b1;
          end else begin
            link_val_a = head_idx;
            link_we_b  = 1'b1;
            if (cmd == clle_pkg::CMD_APPEND) tail_nxt = free_idx;
          end
        end
      end
      clle_pkg::CMD_FIRST: begin
        if (!nonempty_r) begin
          res_status = clle_pkg::ST_EMPTY;
        end else begin
          prv_nxt       = tail_r;
          cur_nxt       = head_idx;
          cur_valid_nxt = 1'b1;
          res_data      = node_data_r[rd_idx];
        end
      end
      clle_pkg::CMD_NEXT: begin
        if (!nonempty_r) begin
          res_status = clle_pkg::ST_EMPTY;
        end else if (!cur_valid_r || !slot_used_r[cur_r]) begin
          res_status = clle_pkg::ST_NOCUR;
        end else begin
          prv_nxt  = cur_r;
          cur_nxt  = cur_link;
          res_data = node_data_r[rd_idx];
        end
      end
      clle_pkg::CMD_REMOVE: begin
        if (!nonempty_r) begin
          res_status = clle_pkg::ST_EMPTY;
        end else if (!cur_valid_r || !slot_used_r[cur_r] || !slot_used_r[prv_r] ||
                     prv_link != cur_r) begin
          // stale predecessor or no cursor
          res_status = clle_pkg::ST_NOCUR;
        end else begin
          res_data = node_data_r[rd_idx];
          if (cur_r == tail_r) begin
            if (cur_link == cur_r) nonempty_nxt = 1'b0;
            else tail_nxt = prv_r;
          end
          link_we_a            = 1'b1;
          link_idx_a           = prv_r;
          link_val_a           = cur_link;
          slot_used_nxt[cur_r] = 1'b0;
          cur_nxt              = prv_r;
          if (count_r != '0) count_nxt = count_r - 1'b1;
          if (!nonempty_nxt) begin
            cur_valid_nxt = 1'b0;
            count_nxt     = '0;
          end
        end
      end
      default: begin
        // unknown command: no change
      end
    endcase

    res_count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r <= '0;
      tail_r      <= '0;
      nonempty_r  <= 1'b0;
      cur_r       <= '0;
      prv_r       <= '0;
      cur_valid_r <= 1'b0;
      count_r     <= '0;
    end else if (fire) begin
      slot_used_r <= slot_used_nxt;
      tail_r      <= tail_nxt;
      nonempty_r  <= nonempty_nxt;
      cur_r       <= cur_nxt;
      prv_r       <= prv_nxt;
      cur_valid_r <= cur_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  // node pool carries no reset; entries are only read once written
  always_ff @(posedge clk) begin
    if (fire && data_we) node_data_r[data_widx] <= data_in;
    if (fire && link_we_a) node_link_r[link_idx_a] <= link_val_a;
    if (fire && link_we_b) node_link_r[link_idx_b] <= link_val_b;
  end

endmodule

### src/clle_checker.sv
// Port-level checks for the circular linked list engine, bound to the top level.
// Depends on clle_pkg and circular_linked_list_engine_top.
module clle_checker #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [DATA_WIDTH-1:0]         out_data,
  input clle_pkg::status_t             out_status,
  input logic [$clog2(CAPACITY+1)-1:0] out_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_count))
    else $error("result word changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == clle_pkg::ST_FULL |-> out_count == CW'(CAPACITY))
    else $error("pool full reported below capacity");

  a_fail_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == clle_pkg::ST_EMPTY || out_status == clle_pkg::ST_NOCUR)
    |-> out_data == '0 && (out_status != clle_pkg::ST_EMPTY || out_count == '0))
    else $error("failed command returned data or empty list with entries");

endmodule

bind circular_linked_list_engine_top clle_checker #(
  .CAPACITY   (CAPACITY),
  .DATA_WIDTH (DATA_WIDTH)
) u_clle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_data   (out_ch.data_out),
  .out_status (out_ch.status),
  .out_count  (out_ch.count)
);
